FILE: rtl/core/spbq_pkg.sv
// Shared constants, codes and types of the strict-priority band queue.
package spbq_pkg;

    localparam int NUM_BANDS   = 16;
    localparam int BAND_DEPTH  = 64;
    localparam int MAP_ENTRIES = 16;

    localparam int BAND_W      = $clog2(NUM_BANDS);
    localparam int PTR_W       = $clog2(BAND_DEPTH);
    localparam int FILL_W      = $clog2(BAND_DEPTH + 1);
    localparam int STORE_DEPTH = NUM_BANDS * BAND_DEPTH;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int TOTAL_W     = $clog2(STORE_DEPTH + 1);

    // Field widths fixed by the interface.
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 3;
    localparam int PRIO_W    = 32;
    localparam int ID_W      = 16;
    localparam int LEN_W     = 16;
    localparam int COUNT_W   = 32;
    localparam int NB_W      = 5;
    localparam int MAP_W     = 64;
    localparam int MAJOR_W   = 16;
    localparam int LIMIT_W   = 7;
    localparam int CFG_AW    = 2;
    localparam int CFG_DW    = 64;
    localparam int WORD_W    = ID_W + LEN_W;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] CFG_BAND_COUNT = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_BAND_MAP   = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_OWN_MAJOR  = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_BAND_LIMIT = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [NB_W-1:0]    RST_BAND_COUNT = 5'd3;
    localparam logic [MAP_W-1:0]   RST_BAND_MAP   = 64'h1111_1111_0021_2221;
    localparam logic [MAJOR_W-1:0] RST_OWN_MAJOR  = '0;
    localparam logic [LIMIT_W-1:0] RST_BAND_LIMIT = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ  = 2'd0,
        OP_REQ  = 2'd1,
        OP_DEQ  = 2'd2,
        OP_DROP = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPT = 3'd0,
        ST_REJECT = 3'd1,
        ST_DEQ    = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_DROP   = 3'd4,
        ST_NODROP = 3'd5
    } status_t;

    // One entry of the band pointer memory.
    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic [PTR_W-1:0]  tail;
        logic [PTR_W-1:0]  head;
    } band_ptr_t;

    localparam int PTR_ENTRY_W = $bits(band_ptr_t);

endpackage

FILE: rtl/core/spbq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module spbq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/strict_priority_band_queue_core.sv
// Strict-priority band queue: up to sixteen FIFO bands of packet descriptors
// (id and length) held in one 1024-word descriptor memory, with head, tail and
// fill of every band in a small pointer memory. Each item is one operation:
// enqueue, requeue at head, dequeue from the lowest non-empty band, or drop the
// tail of the highest non-empty band. In the accept cycle the band is chosen
// and the band's pointer entry is read; in the next cycle the pointers are
// updated and written back and the descriptor memory is written or read; then
// the result is loaded into the output register as soon as it is free, which
// is also the cycle in which the next item may be accepted. The single read
// port of the pointer memory and the registered read data of both memories
// set this sequence. A stalled result channel holds the block in its last
// step until the output register frees up.
// No clearing pass is needed after reset: pointer entries carry valid bits and
// descriptor slots are only read once written. Configuration writes are taken
// at any time and must only be issued while the block is idle.
module strict_priority_band_queue_core
    import spbq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // Configuration write port.
    input  logic                 cfg_wr_en,
    input  logic [CFG_AW-1:0]    cfg_addr,
    input  logic [CFG_DW-1:0]    cfg_wdata,

    // Input items.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: packet_priority[31:0], packet_id[47:32], packet_length[63:48]
    input  logic [63:0]          s_tdata,
    // s_tuser: opcode[1:0]
    input  logic [OP_W-1:0]      s_tuser,

    // Result items.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: out_packet_id[15:0], out_packet_length[31:16], band_used[35:32],
    //          total_queued[46:36], reject_total[78:47], zero[79]
    output logic [79:0]          m_tdata,
    // m_tuser: status[2:0]
    output logic [STATUS_W-1:0]  m_tuser
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [NB_W-1:0]    band_count_reg;
    logic [MAP_W-1:0]   band_map_reg;
    logic [MAJOR_W-1:0] own_major_reg;
    logic [LIMIT_W-1:0] band_limit_reg;

    // Control state kept in flip-flops.
    logic [NUM_BANDS-1:0] ptr_valid_reg;
    logic [NUM_BANDS-1:0] nonempty_reg;
    logic [TOTAL_W-1:0]   total_queued_reg;
    logic [COUNT_W-1:0]   reject_total_reg;

    // Item captured at accept.
    op_t               op_reg;
    logic [BAND_W-1:0] band_reg;
    logic              band_ok_reg;
    logic [ID_W-1:0]   id_reg;
    logic [LEN_W-1:0]  len_reg;

    // Result waiting for the output register.
    status_t           res_status_reg;
    logic [BAND_W-1:0] res_used_reg;
    logic              res_take_reg;

    // Output register.
    logic                m_tvalid_reg;
    logic [79:0]         m_tdata_reg;
    logic [STATUS_W-1:0] m_tuser_reg;

    logic in_fire;
    logic out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) || ((state_reg == S_OUT) && out_free);
    assign in_fire  = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------
    // Band choice in the accept cycle.
    // ------------------------------------------------------------------
    logic [PRIO_W-1:0]  in_prio;
    logic [MAJOR_W-1:0] in_major;
    logic [15:0]        in_minor;
    logic [NB_W-1:0]    nb;
    logic [BAND_W-1:0]  sel_band;
    logic               sel_ok;

    assign in_prio  = s_tdata[31:0];
    assign in_major = in_prio[31:16];
    assign in_minor = in_prio[15:0];

    // A band count of zero acts as one; a count above the band total saturates.
    always_comb begin
        priority if (band_count_reg == '0) begin
            nb = NB_W'(1);
        end else if (band_count_reg > NB_W'(NUM_BANDS)) begin
            nb = NB_W'(NUM_BANDS);
        end else begin
            nb = band_count_reg;
        end
    end

    always_comb begin
        logic                  direct;
        logic                  direct_ok;
        logic [BAND_W-1:0]     direct_band;
        logic [BAND_W-1:0]     map_idx;
        logic [BAND_W-1:0]     map_band;
        logic                  map_ok;
        logic [BAND_W-1:0]     pick_band;
        logic                  named;
        logic [NUM_BANDS-1:0]  avail;
        logic [BAND_W-1:0]     deq_band;
        logic [BAND_W-1:0]     drop_band;

        // A major half equal to the own handle makes the minor half a direct
        // band number, counted from one.
        direct      = (in_major == own_major_reg);
        direct_ok   = (in_minor != '0) && (in_minor <= 16'(nb));
        direct_band = BAND_W'(in_minor - 16'd1);

        // Otherwise the low bits index the map; a foreign nonzero major uses
        // the first map entry.
        map_idx  = (in_major != '0) ? '0 : in_prio[BAND_W-1:0];
        map_band = band_map_reg[map_idx*BAND_W +: BAND_W];
        map_ok   = (NB_W'(map_band) < nb);

        pick_band = direct ? direct_band : map_band;

        // Bands that no map entry names take no packets.
        named = 1'b0;
        for (int i = 0; i < MAP_ENTRIES; i++) begin
            if (band_map_reg[i*BAND_W +: BAND_W] == pick_band) begin
                named = 1'b1;
            end
        end

        // Only bands below the band count are served or dropped from.
        for (int i = 0; i < NUM_BANDS; i++) begin
            avail[i] = nonempty_reg[i] && (NB_W'(i) < nb);
        end

        deq_band = '0;
        for (int i = NUM_BANDS - 1; i >= 0; i--) begin
            if (avail[i]) begin
                deq_band = BAND_W'(i);
            end
        end

        drop_band = '0;
        for (int i = 0; i < NUM_BANDS; i++) begin
            if (avail[i]) begin
                drop_band = BAND_W'(i);
            end
        end

        unique case (op_t'(s_tuser))
            OP_ENQ, OP_REQ: begin
                sel_band = pick_band;
                sel_ok   = (direct ? direct_ok : map_ok) && named;
            end
            OP_DEQ: begin
                sel_band = deq_band;
                sel_ok   = |avail;
            end
            OP_DROP: begin
                sel_band = drop_band;
                sel_ok   = |avail;
            end
            default: begin
                sel_band = '0;
                sel_ok   = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Memories.
    // ------------------------------------------------------------------
    logic                   ptr_we;
    band_ptr_t              ptr_new;
    logic [PTR_ENTRY_W-1:0] ptr_rdata;

    logic                   store_we;
    logic [STORE_AW-1:0]    store_waddr;
    logic                   store_re;
    logic [STORE_AW-1:0]    store_raddr;
    logic [WORD_W-1:0]      store_rdata;

    spbq_ram #(
        .WIDTH(PTR_ENTRY_W),
        .DEPTH(NUM_BANDS)
    ) u_ptr_ram (
        .aclk    (aclk),
        .wr_en   (ptr_we),
        .wr_addr (band_reg),
        .wr_data (ptr_new),
        .rd_en   (in_fire),
        .rd_addr (sel_band),
        .rd_data (ptr_rdata)
    );

    spbq_ram #(
        .WIDTH(WORD_W),
        .DEPTH(STORE_DEPTH)
    ) u_store_ram (
        .aclk    (aclk),
        .wr_en   (store_we),
        .wr_addr (store_waddr),
        .wr_data ({id_reg, len_reg}),
        .rd_en   (store_re),
        .rd_addr (store_raddr),
        .rd_data (store_rdata)
    );

    // ------------------------------------------------------------------
    // Pointer update in the execute cycle. The pointer memory is written here
    // and read no earlier than the following cycle, so no forwarding is needed.
    // ------------------------------------------------------------------
    band_ptr_t         ptr_cur;
    logic [FILL_W-1:0] limit_use;
    status_t           ex_status;
    logic [BAND_W-1:0] ex_used;
    logic              ex_take;
    logic              ex_inc;
    logic              ex_dec;

    assign limit_use = (band_limit_reg > LIMIT_W'(BAND_DEPTH)) ? FILL_W'(BAND_DEPTH)
                                                               : FILL_W'(band_limit_reg);

    always_comb begin
        ptr_cur     = ptr_valid_reg[band_reg] ? band_ptr_t'(ptr_rdata) : '0;
        ptr_new     = ptr_cur;
        ptr_we      = 1'b0;
        store_we    = 1'b0;
        store_re    = 1'b0;
        store_waddr = {band_reg, ptr_cur.tail};
        store_raddr = {band_reg, ptr_cur.head};
        ex_status   = ST_REJECT;
        ex_used     = '0;
        ex_take     = 1'b0;
        ex_inc      = 1'b0;
        ex_dec      = 1'b0;

        unique case (op_reg)
            OP_ENQ, OP_REQ: begin
                if (!band_ok_reg) begin
                    ex_status = ST_REJECT;
                end else if (ptr_cur.fill >= limit_use) begin
                    ex_status = ST_REJECT;
                    ex_used   = band_reg;
                end else begin
                    if (op_reg == OP_ENQ) begin
                        store_waddr  = {band_reg, ptr_cur.tail};
                        ptr_new.tail = ptr_cur.tail + PTR_W'(1);
                    end else begin
                        store_waddr  = {band_reg, ptr_cur.head - PTR_W'(1)};
                        ptr_new.head = ptr_cur.head - PTR_W'(1);
                    end
                    ptr_new.fill = ptr_cur.fill + FILL_W'(1);
                    ptr_we       = 1'b1;
                    store_we     = 1'b1;
                    ex_inc       = 1'b1;
                    ex_status    = ST_ACCEPT;
                    ex_used      = band_reg;
                end
            end
            OP_DEQ: begin
                if (band_ok_reg) begin
                    store_raddr  = {band_reg, ptr_cur.head};
                    ptr_new.head = ptr_cur.head + PTR_W'(1);
                    ptr_new.fill = ptr_cur.fill - FILL_W'(1);
                    ptr_we       = 1'b1;
                    store_re     = 1'b1;
                    ex_dec       = 1'b1;
                    ex_take      = 1'b1;
                    ex_status    = ST_DEQ;
                    ex_used      = band_reg;
                end else begin
                    ex_status = ST_EMPTY;
                end
            end
            OP_DROP: begin
                if (band_ok_reg) begin
                    store_raddr  = {band_reg, ptr_cur.tail - PTR_W'(1)};
                    ptr_new.tail = ptr_cur.tail - PTR_W'(1);
                    ptr_new.fill = ptr_cur.fill - FILL_W'(1);
                    ptr_we       = 1'b1;
                    store_re     = 1'b1;
                    ex_dec       = 1'b1;
                    ex_take      = 1'b1;
                    ex_status    = ST_DROP;
                    ex_used      = band_reg;
                end else begin
                    ex_status = ST_NODROP;
                end
            end
            default: begin
                ex_status = ST_REJECT;
            end
        endcase

        // Memory writes happen only in the execute cycle.
        if (state_reg != S_EXEC) begin
            ptr_we   = 1'b0;
            store_we = 1'b0;
            store_re = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer, state and registered outputs.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            band_count_reg   <= RST_BAND_COUNT;
            band_map_reg     <= RST_BAND_MAP;
            own_major_reg    <= RST_OWN_MAJOR;
            band_limit_reg   <= RST_BAND_LIMIT;
            ptr_valid_reg    <= '0;
            nonempty_reg     <= '0;
            total_queued_reg <= '0;
            reject_total_reg <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_BAND_COUNT: band_count_reg <= cfg_wdata[NB_W-1:0];
                    CFG_BAND_MAP:   band_map_reg   <= cfg_wdata[MAP_W-1:0];
                    CFG_OWN_MAJOR:  own_major_reg  <= cfg_wdata[MAJOR_W-1:0];
                    CFG_BAND_LIMIT: band_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end

            // A result is loaded whenever the output register is free in the
            // last step; otherwise a taken result empties it.
            if ((state_reg == S_OUT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (in_fire) begin
                op_reg      <= op_t'(s_tuser);
                band_reg    <= sel_band;
                band_ok_reg <= sel_ok;
                id_reg      <= s_tdata[47:32];
                len_reg     <= s_tdata[63:48];
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (ptr_we) begin
                        ptr_valid_reg[band_reg] <= 1'b1;
                        nonempty_reg[band_reg]  <= (ptr_new.fill != '0);
                    end
                    if (ex_inc) begin
                        total_queued_reg <= total_queued_reg + TOTAL_W'(1);
                    end else if (ex_dec) begin
                        total_queued_reg <= total_queued_reg - TOTAL_W'(1);
                    end
                    if (ex_status == ST_REJECT) begin
                        reject_total_reg <= reject_total_reg + COUNT_W'(1);
                    end
                    res_status_reg <= ex_status;
                    res_used_reg   <= ex_used;
                    res_take_reg   <= ex_take;
                    state_reg      <= S_OUT;
                end
                S_OUT: begin
                    // The descriptor read issued in the execute cycle is
                    // available now.
                    if (out_free) begin
                        m_tuser_reg  <= res_status_reg;
                        m_tdata_reg  <= {1'b0,
                                         reject_total_reg,
                                         total_queued_reg,
                                         res_used_reg,
                                         res_take_reg ? store_rdata[LEN_W-1:0]
                                                      : {LEN_W{1'b0}},
                                         res_take_reg ? store_rdata[WORD_W-1:LEN_W]
                                                      : {ID_W{1'b0}}};
                        state_reg    <= in_fire ? S_EXEC : S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_queued_reg <= TOTAL_W'(STORE_DEPTH))
        else $error("queued total exceeds the descriptor store");

    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg == S_EXEC))
        else $error("accepted item did not enter the execute step");

    a_enq_marks_band: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_EXEC) && (ex_status == ST_ACCEPT))
            |=> nonempty_reg[band_reg])
        else $error("accepted packet left its band marked empty");

    a_take_status: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_OUT) && res_take_reg)
            |-> ((res_status_reg == ST_DEQ) || (res_status_reg == ST_DROP)))
        else $error("descriptor returned with a status that carries none");

endmodule
